// ===== sv/cbvs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbvs_pkg: shared types and constants for the column bitmask voxel store
// Port widths, default geometry, controller states and the command/status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package cbvs_pkg;

  // Default geometry
  localparam int CHUNK_SIDE_DEF       = 32;
  localparam int SLOTS_PER_COLUMN_DEF = 8;
  localparam int ID_BITS_DEF          = 16;

  // Height of one column, one mask bit per height
  localparam int MASK_HEIGHT = 32;

  // Stream payload widths
  localparam int COORD_W     = 5;
  localparam int IN_ID_W     = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int PRIOR_W     = 16;
  localparam int OUT_TDATA_W = 16;

  // Request modes
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_RD    = 4'b0100,
    ST_CALC  = 4'b1000
  } cbvs_state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_step;  // zero one mask row, advance sweep counter
    logic load;        // capture request fields
    logic read;        // read the column's slot rows
    logic commit;      // write back the column on a write, load the result register
  } cbvs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;  // sweep counter sits on the last column
  } cbvs_stat_t;

endpackage : cbvs_pkg
`default_nettype wire

// ===== sv/cbvs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbvs_ctrl: sequencer for the voxel store
// Runs the post-reset mask clear, then walks each request through
// capture, column read and commit, and owns the result valid flag.
// ----------------------------------------------------------------------------
module cbvs_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output cbvs_pkg::cbvs_cmd_t   cmd,
  input  cbvs_pkg::cbvs_stat_t  stat
);
  import cbvs_pkg::*;

  cbvs_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        cmd.read  = 1'b1;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Result valid: set on commit, dropped when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted request always goes on to the column read
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_RD))
    else $error("accepted request did not start a column read");

  // A column read is always followed by the compute state
  a_read_then_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |=> (state_r == ST_CALC))
    else $error("column read not followed by compute");

  // A commit always presents a result
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_tvalid)
    else $error("commit did not present a result");

  // No request is taken while the mask clear runs
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!in_tready && !out_tvalid))
    else $error("stream activity during mask clear");
`endif

endmodule : cbvs_ctrl
`default_nettype wire

// ===== sv/cbvs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbvs_datapath: column memories, slot scan and result register
// One memory row per column holds all slot masks, a second holds all slot
// ids. A request reads both rows, finds the occupant, the matching or free
// slot, and on a write writes the updated rows back.
// ----------------------------------------------------------------------------
module cbvs_datapath #(
  parameter int CHUNK_SIDE       = cbvs_pkg::CHUNK_SIDE_DEF,
  parameter int SLOTS_PER_COLUMN = cbvs_pkg::SLOTS_PER_COLUMN_DEF,
  parameter int ID_BITS          = cbvs_pkg::ID_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  cbvs_pkg::cbvs_cmd_t          cmd,
  output cbvs_pkg::cbvs_stat_t         stat,
  input  wire                          in_mode,
  input  wire  [cbvs_pkg::COORD_W-1:0] in_x,
  input  wire  [cbvs_pkg::COORD_W-1:0] in_y,
  input  wire  [cbvs_pkg::COORD_W-1:0] in_z,
  input  wire  [cbvs_pkg::IN_ID_W-1:0] in_id,
  output logic [cbvs_pkg::PRIOR_W-1:0] prior_id,
  output logic                         overflow
);
  import cbvs_pkg::*;

  localparam int COLUMNS  = CHUNK_SIDE * CHUNK_SIDE;
  localparam int SIDE_W   = $clog2(CHUNK_SIDE);
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int SLOTS    = SLOTS_PER_COLUMN;
  localparam int MROW_W   = SLOTS * MASK_HEIGHT;
  localparam int IROW_W   = SLOTS * ID_BITS;

  // Column memories
  logic [MROW_W-1:0] mask_mem [COLUMNS];
  logic [IROW_W-1:0] id_mem   [COLUMNS];

  logic [MROW_W-1:0] mask_rd_r;
  logic [IROW_W-1:0] id_rd_r;

  // Captured request
  logic               mode_r;
  logic [COORD_W-1:0] y_r;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ID_BITS-1:0] wid_r, wid_nxt;

  // Clear sweep
  logic [COL_W-1:0]   clr_cnt_r, clr_cnt_nxt;

  // Result register
  logic [PRIOR_W-1:0] prior_r, prior_nxt;
  logic               ovf_r, ovf_nxt;

  // Scan signals
  logic [MASK_HEIGHT-1:0] bitsel;
  logic [SLOTS-1:0]       hit, occ_oh, match, free, match_oh, free_oh, tgt_oh;
  logic [ID_BITS-1:0]     occ_id;
  logic [MROW_W-1:0]      mask_clr, mask_new;
  logic [IROW_W-1:0]      id_new;
  logic                   id_nz;
  logic [SIDE_W-1:0]      x_m, z_m;
  logic [31:0]            id_ext, prior_ext;

  // Coordinate wrap, a 32-entry table per coordinate
  function automatic logic [SIDE_W-1:0] wrap_side(input logic [COORD_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (v == COORD_W'(i)) begin
        r = SIDE_W'(i % CHUNK_SIDE);
      end
    end
    return r;
  endfunction

  // Request capture: column address and masked id
  always_comb begin
    x_m     = wrap_side(in_x);
    z_m     = wrap_side(in_z);
    col_nxt = COL_W'(COL_W'(z_m) * COL_W'(CHUNK_SIDE) + COL_W'(x_m));
    id_ext  = {16'd0, in_id};
    wid_nxt = id_ext[ID_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      y_r    <= in_y;
      col_r  <= col_nxt;
      wid_r  <= wid_nxt;
    end
  end

  // Clear sweep counter
  assign clr_cnt_nxt     = cmd.clear_step ? clr_cnt_r + COL_W'(1) : clr_cnt_r;
  assign stat.clear_last = (clr_cnt_r == COL_W'(COLUMNS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Slot scan over the registered column rows
  always_comb begin
    bitsel = MASK_HEIGHT'(1) << y_r;
    id_nz  = (wid_r != '0);
    occ_id = '0;
    for (int s = 0; s < SLOTS; s++) begin
      hit[s] = mask_rd_r[s*MASK_HEIGHT + int'(y_r)];
    end
    // first occupant, lowest slot wins
    occ_oh = hit & (~hit + SLOTS'(1));
    for (int s = 0; s < SLOTS; s++) begin
      if (occ_oh[s]) begin
        occ_id = occ_id | id_rd_r[s*ID_BITS +: ID_BITS];
      end
    end
    // masks after removing the old occupant
    for (int s = 0; s < SLOTS; s++) begin
      mask_clr[s*MASK_HEIGHT +: MASK_HEIGHT] = mask_rd_r[s*MASK_HEIGHT +: MASK_HEIGHT] &
        ~(occ_oh[s] ? bitsel : '0);
      free[s]  = (mask_clr[s*MASK_HEIGHT +: MASK_HEIGHT] == '0);
      match[s] = !free[s] && (id_rd_r[s*ID_BITS +: ID_BITS] == wid_r);
    end
    // live matching slot first, else first free slot
    match_oh = match & (~match + SLOTS'(1));
    free_oh  = free & (~free + SLOTS'(1));
    tgt_oh   = (match != '0) ? match_oh : free_oh;
    if (!id_nz) begin
      tgt_oh = '0;
    end
    // updated rows
    for (int s = 0; s < SLOTS; s++) begin
      mask_new[s*MASK_HEIGHT +: MASK_HEIGHT] = mask_clr[s*MASK_HEIGHT +: MASK_HEIGHT] |
        (tgt_oh[s] ? bitsel : '0);
      id_new[s*ID_BITS +: ID_BITS] = tgt_oh[s] ? wid_r : id_rd_r[s*ID_BITS +: ID_BITS];
    end
    prior_ext = 32'(occ_id);
    prior_nxt = prior_ext[PRIOR_W-1:0];
    ovf_nxt   = (mode_r == MODE_WRITE) && id_nz && (tgt_oh == '0);
  end

  // Mask memory: clear sweep or write-back, registered read
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mask_mem[clr_cnt_r] <= '0;
    end else if (cmd.commit && (mode_r == MODE_WRITE)) begin
      mask_mem[col_r] <= mask_new;
    end
    if (cmd.read) begin
      mask_rd_r <= mask_mem[col_r];
    end
  end

  // Id memory: write-back, registered read
  always_ff @(posedge clk) begin
    if (cmd.commit && (mode_r == MODE_WRITE)) begin
      id_mem[col_r] <= id_new;
    end
    if (cmd.read) begin
      id_rd_r <= id_mem[col_r];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      prior_r <= prior_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign prior_id = prior_r;
  assign overflow = ovf_r;

endmodule : cbvs_datapath
`default_nettype wire

// ===== sv/column_bitmask_voxel_store_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// column_bitmask_voxel_store_unit: voxel store for one chunk
// Per-column slot store of block ids with height masks; read or write
// requests in, one result (prior id, overflow) out per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ stream: in_tuser is the mode (0 read,
//   1 write), in_tdata carries the position and the id to write.
//   Every request gives exactly one result on the out_ stream: the id at
//   the position before the request, and in out_tuser the overflow flag
//   of a write that found neither a slot with its id nor a free slot.
//   A taken request passes the column read and the slot scan, and its
//   result is registered at its write-back. No new request is taken
//   until the last has done the column memory read, the slot scan and
//   the write-back (on a write) that each request performs in turn.
//   After reset the mask memory is swept to zero, one column per cycle,
//   over all CHUNK_SIDE*CHUNK_SIDE columns (1024 by default); in_tready
//   stays low until the sweep ends.
//   A pending result may wait while the next request is taken and read;
//   if out_tready stays low, that request holds before its write-back
//   until the result register frees.
// ----------------------------------------------------------------------------
module column_bitmask_voxel_store_unit #(
  parameter int CHUNK_SIDE       = cbvs_pkg::CHUNK_SIDE_DEF,
  parameter int SLOTS_PER_COLUMN = cbvs_pkg::SLOTS_PER_COLUMN_DEF,
  parameter int ID_BITS          = cbvs_pkg::ID_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // x_pos[4:0], y_pos[9:5], z_pos[14:10], block_id[30:15], zero[31]
  input  wire  [cbvs_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode[0]
  input  wire                              in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // prior_id[15:0]
  output logic [cbvs_pkg::OUT_TDATA_W-1:0] out_tdata,
  // overflow[0]
  output logic                             out_tuser
);
  import cbvs_pkg::*;

  cbvs_cmd_t  cmd;
  cbvs_stat_t stat;

  logic [PRIOR_W-1:0] prior_id;
  logic               overflow;

  cbvs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  cbvs_datapath #(
    .CHUNK_SIDE       (CHUNK_SIDE),
    .SLOTS_PER_COLUMN (SLOTS_PER_COLUMN),
    .ID_BITS          (ID_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_mode  (in_tuser),
    .in_x     (in_tdata[4:0]),
    .in_y     (in_tdata[9:5]),
    .in_z     (in_tdata[14:10]),
    .in_id    (in_tdata[30:15]),
    .prior_id (prior_id),
    .overflow (overflow)
  );

  assign out_tdata = prior_id;
  assign out_tuser = overflow;

endmodule : column_bitmask_voxel_store_unit
`default_nettype wire
